// ===== hw/rtl/tlbpt_pkg.sv =====
package tlbpt_pkg;

  // Fixed field widths of the ports and configuration registers.
  localparam int VA_BITS       = 10;
  localparam int OFF_BITS      = 4;
  localparam int TLBN_BITS     = 5;
  localparam int FRN_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;

  // Configuration values after reset.
  localparam logic [OFF_BITS-1:0]  RST_OFFSET_BITS = 4'd2;
  localparam logic [TLBN_BITS-1:0] RST_TLB_ENTRIES = 5'd10;
  localparam logic [FRN_BITS-1:0]  RST_FRAMES      = 8'd32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_TLB_ENTRIES = 2'd1,
    CFG_FRAMES      = 2'd2
  } cfg_idx_t;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    OUT_TLB_HIT       = 3'd0,
    OUT_PT_HIT        = 3'd1,
    OUT_FRAME_LOST    = 3'd2,
    OUT_PAGE_LOAD     = 3'd3,
    OUT_READ_MAPPED   = 3'd4,
    OUT_READ_UNMAPPED = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_REDUCE = 3'd2,
    S_SCAN   = 3'd3,
    S_FRD    = 3'd4,
    S_DEC    = 3'd5
  } state_t;

endpackage

// ===== hw/rtl/tlbpt_if.sv =====
interface tlbpt_in_if #(
  parameter int DATA_BITS = 32
);
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [tlbpt_pkg::VA_BITS-1:0]    virtual_address;
  logic [DATA_BITS-1:0]             data_word;

  modport source (output valid, kind, virtual_address, data_word, input ready);
  modport sink   (input valid, kind, virtual_address, data_word, output ready);
endinterface

interface tlbpt_out_if #(
  parameter int DATA_BITS  = 32,
  parameter int FRAME_BITS = 7
);
  logic                  valid;
  logic                  ready;
  tlbpt_pkg::outcome_t   outcome;
  logic [FRAME_BITS-1:0] frame;
  logic [DATA_BITS-1:0]  read_data;
  logic                  dirty_set;

  modport source (output valid, outcome, frame, read_data, dirty_set, input ready);
  modport sink   (input valid, outcome, frame, read_data, dirty_set, output ready);
endinterface

// ===== hw/rtl/tlb_page_table_translator_unit.sv =====
// Sequence: an accepted beat's page number is first folded into the page table range,
// one subtraction per wrap of a page number at or above PAGE_TABLE_DEPTH; an access beat
// then scans the TLB slots in use until a match or the last slot; the frame store is
// read, and the decision step waits for a free output register to load the result.
// One beat at a time: the next beat is taken only after the last result is produced.
// Reset (rst_n, synchronous, active low) clears control state and valid bits, loads the
// reset configuration, then sweeps the page table; no input beat is accepted meanwhile.
module tlb_page_table_translator_unit #(
  parameter int TLB_DEPTH        = 16,
  parameter int PAGE_TABLE_DEPTH = 1024,
  parameter int FRAME_DEPTH      = 128,
  parameter int DATA_BITS        = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  tlbpt_in_if.sink                              in_ch,
  tlbpt_out_if.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [tlbpt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tlbpt_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  // The block is a small sequencer around one shared compare unit. After an input
  // beat is taken, the page number (address shifted right by the offset) is folded
  // into the page table range, then the TLB slots in use are compared one per cycle
  // against the page. The page table read is issued as the scan starts, so its data
  // is ready when the candidate frame is chosen. The frame store is read next, and
  // the decision step, once the output register is free, loads it and, for an access,
  // writes the TLB and, where needed, the frame store and page table.

  localparam int TLB_AW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int TLB_CW = $clog2(TLB_DEPTH + 1);
  localparam int PT_AW  = $clog2(PAGE_TABLE_DEPTH);
  localparam int PG_W   = (PT_AW > tlbpt_pkg::VA_BITS) ? PT_AW : tlbpt_pkg::VA_BITS;
  localparam int FR_AW  = $clog2(FRAME_DEPTH);
  localparam int FR_CW  = $clog2(FRAME_DEPTH + 1);

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [FR_AW-1:0] frame;
  } pt_ent_t;

  typedef struct packed {
    logic                 owned;
    logic [PT_AW-1:0]     page;
    logic [DATA_BITS-1:0] data;
  } fr_ent_t;

  typedef struct packed {
    logic [PT_AW-1:0] page;
    logic [FR_AW-1:0] frame;
  } tlb_ent_t;

  // Sequencer state and configuration.
  tlbpt_pkg::state_t                state_r, state_nxt;
  logic [tlbpt_pkg::OFF_BITS-1:0]   off_r;
  logic [tlbpt_pkg::TLBN_BITS-1:0]  tlbn_r;
  logic [tlbpt_pkg::FRN_BITS-1:0]   frn_r;
  logic [PT_AW-1:0]                 clr_r;

  // Item being worked on.
  logic                  kind_r;
  logic [DATA_BITS-1:0]  data_r;
  logic [PG_W-1:0]       page_r;
  logic [TLB_CW-1:0]     scan_r;
  logic                  hit_r;
  logic [TLB_AW-1:0]     slot_r;
  logic [FR_AW-1:0]      fcand_r;
  logic                  fvld_q_r;
  pt_ent_t               pt_q_r;
  fr_ent_t               fr_q_r;

  // Translation state.
  logic [TLB_DEPTH-1:0]  tlb_vld_r;
  tlb_ent_t              tlb_ent_r [TLB_DEPTH];
  logic [TLB_AW-1:0]     tlb_ptr_r;
  logic [FR_AW-1:0]      fr_ptr_r;
  logic [FRAME_DEPTH-1:0] fr_vld_r;
  pt_ent_t               pt_mem [PAGE_TABLE_DEPTH];
  fr_ent_t               fr_mem [FRAME_DEPTH];

  // Output register.
  logic                  out_valid_r;
  tlbpt_pkg::outcome_t   outcome_r;
  logic [FR_AW-1:0]      frame_r;
  logic [DATA_BITS-1:0]  rdata_r;
  logic                  dset_r;

  // Limits and FIFO pointers, with a pointer past the limit wrapping to zero.
  logic [31:0]           tlb_lim_w, fr_lim_w;
  logic [TLB_CW-1:0]     tlb_lim;
  logic [FR_CW-1:0]      fr_lim;
  logic [TLB_AW-1:0]     tlb_ptr_eff, tlb_ptr_adv;
  logic [TLB_CW-1:0]     tlb_ptr_inc;
  logic [FR_AW-1:0]      fr_ptr_eff, fr_ptr_adv;
  logic [FR_CW-1:0]      fr_ptr_inc;

  always_comb begin
    if (tlbn_r == '0) begin
      tlb_lim_w = 32'd1;
    end else if (32'(tlbn_r) > 32'(TLB_DEPTH)) begin
      tlb_lim_w = 32'(TLB_DEPTH);
    end else begin
      tlb_lim_w = 32'(tlbn_r);
    end
    if (frn_r == '0) begin
      fr_lim_w = 32'd1;
    end else if (32'(frn_r) > 32'(FRAME_DEPTH)) begin
      fr_lim_w = 32'(FRAME_DEPTH);
    end else begin
      fr_lim_w = 32'(frn_r);
    end
  end

  assign tlb_lim     = tlb_lim_w[TLB_CW-1:0];
  assign fr_lim      = fr_lim_w[FR_CW-1:0];
  assign tlb_ptr_eff = (TLB_CW'(tlb_ptr_r) >= tlb_lim) ? '0 : tlb_ptr_r;
  assign tlb_ptr_inc = TLB_CW'(tlb_ptr_eff) + TLB_CW'(1);
  assign tlb_ptr_adv = (tlb_ptr_inc >= tlb_lim) ? '0 : tlb_ptr_inc[TLB_AW-1:0];
  assign fr_ptr_eff  = (FR_CW'(fr_ptr_r) >= fr_lim) ? '0 : fr_ptr_r;
  assign fr_ptr_inc  = FR_CW'(fr_ptr_eff) + FR_CW'(1);
  assign fr_ptr_adv  = (fr_ptr_inc >= fr_lim) ? '0 : fr_ptr_inc[FR_AW-1:0];

  // Shared compare unit: one TLB slot per cycle against the current page.
  logic [PT_AW-1:0]             page_idx;
  logic [TLB_AW-1:0]            scan_idx;
  logic                         tlb_match;
  logic                         scan_last;
  logic [tlbpt_pkg::VA_BITS-1:0] page_shift;
  logic                         page_big;

  assign page_idx   = page_r[PT_AW-1:0];
  assign scan_idx   = scan_r[TLB_AW-1:0];
  assign tlb_match  = tlb_vld_r[scan_idx] && (tlb_ent_r[scan_idx].page == page_idx);
  assign scan_last  = (scan_r + TLB_CW'(1)) >= tlb_lim;
  assign page_shift = in_ch.virtual_address >> off_r;
  assign page_big   = 32'(page_r) >= 32'(PAGE_TABLE_DEPTH);

  // Decision on the frame store entry that was read; an entry never written reads
  // as unowned with zero data.
  logic                 fr_own;
  logic [DATA_BITS-1:0] fr_data_eff;
  logic                 mapped;
  logic                 resident;
  logic                 dirty_wr;
  logic                 dec_go;

  assign fr_own      = fvld_q_r & fr_q_r.owned;
  assign fr_data_eff = fvld_q_r ? fr_q_r.data : '0;
  assign mapped      = hit_r | pt_q_r.valid;
  assign resident    = mapped & fr_own & (fr_q_r.page == page_idx);
  assign dirty_wr    = resident & (fr_data_eff != data_r);
  assign dec_go      = !out_valid_r || out_ch.ready;

  // Sequencer outputs.
  logic                 in_ready;
  logic                 ld_in, do_sub, pt_re, scan_clr, scan_inc, hit_set, fr_re;
  logic                 commit, alloc;
  logic                 pt_we;
  logic [PT_AW-1:0]     pt_waddr;
  pt_ent_t              pt_wdata;
  logic                 fr_we;
  logic [FR_AW-1:0]     fr_waddr;
  logic [FR_AW-1:0]     fcand;
  logic                 tlb_we;
  logic [TLB_AW-1:0]    tlb_waddr;
  tlbpt_pkg::outcome_t  res_outcome;
  logic [FR_AW-1:0]     res_frame;
  logic [DATA_BITS-1:0] res_data;
  logic                 res_dset;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    ld_in       = 1'b0;
    do_sub      = 1'b0;
    pt_re       = 1'b0;
    scan_clr    = 1'b0;
    scan_inc    = 1'b0;
    hit_set     = 1'b0;
    fr_re       = 1'b0;
    commit      = 1'b0;
    alloc       = 1'b0;
    pt_we       = 1'b0;
    pt_waddr    = page_idx;
    pt_wdata    = '0;
    fr_we       = 1'b0;
    fr_waddr    = fcand_r;
    tlb_we      = 1'b0;
    tlb_waddr   = hit_r ? slot_r : tlb_ptr_eff;
    res_outcome = tlbpt_pkg::OUT_READ_UNMAPPED;
    res_frame   = '0;
    res_data    = '0;
    res_dset    = 1'b0;
    if (kind_r == tlbpt_pkg::KIND_READ) begin
      fcand = pt_q_r.frame;
    end else begin
      fcand = hit_r ? tlb_ent_r[slot_r].frame : pt_q_r.frame;
    end

    unique case (state_r)
      tlbpt_pkg::S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_r;
        if (clr_r == PT_AW'(PAGE_TABLE_DEPTH - 1)) begin
          state_nxt = tlbpt_pkg::S_IDLE;
        end
      end
      tlbpt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          ld_in     = 1'b1;
          state_nxt = tlbpt_pkg::S_REDUCE;
        end
      end
      tlbpt_pkg::S_REDUCE: begin
        if (page_big) begin
          do_sub = 1'b1;
        end else begin
          pt_re    = 1'b1;
          scan_clr = 1'b1;
          state_nxt = (kind_r == tlbpt_pkg::KIND_READ) ? tlbpt_pkg::S_FRD
                                                       : tlbpt_pkg::S_SCAN;
        end
      end
      tlbpt_pkg::S_SCAN: begin
        if (tlb_match) begin
          hit_set   = 1'b1;
          state_nxt = tlbpt_pkg::S_FRD;
        end else if (scan_last) begin
          state_nxt = tlbpt_pkg::S_FRD;
        end else begin
          scan_inc = 1'b1;
        end
      end
      tlbpt_pkg::S_FRD: begin
        fr_re     = 1'b1;
        state_nxt = tlbpt_pkg::S_DEC;
      end
      tlbpt_pkg::S_DEC: begin
        if (kind_r == tlbpt_pkg::KIND_READ) begin
          if (pt_q_r.valid) begin
            res_outcome = tlbpt_pkg::OUT_READ_MAPPED;
            res_frame   = fcand_r;
            res_data    = fr_data_eff;
          end
        end else if (resident) begin
          res_outcome = hit_r ? tlbpt_pkg::OUT_TLB_HIT : tlbpt_pkg::OUT_PT_HIT;
          res_frame   = fcand_r;
          res_data    = dirty_wr ? data_r : fr_data_eff;
          res_dset    = dirty_wr;
        end else begin
          res_outcome = mapped ? tlbpt_pkg::OUT_FRAME_LOST : tlbpt_pkg::OUT_PAGE_LOAD;
          res_frame   = fr_ptr_eff;
          res_data    = data_r;
        end
        if (dec_go) begin
          commit    = 1'b1;
          state_nxt = tlbpt_pkg::S_IDLE;
          if (kind_r == tlbpt_pkg::KIND_ACCESS) begin
            tlb_we = 1'b1;
            if (!resident) begin
              alloc    = 1'b1;
              fr_we    = 1'b1;
              fr_waddr = fr_ptr_eff;
              pt_we    = 1'b1;
              pt_wdata = '{valid: 1'b1, dirty: 1'b0, frame: fr_ptr_eff};
            end else if (dirty_wr) begin
              fr_we    = 1'b1;
              pt_we    = 1'b1;
              pt_wdata = '{valid: pt_q_r.valid, dirty: 1'b1, frame: pt_q_r.frame};
            end
          end
        end
      end
      default: begin
        state_nxt = tlbpt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlbpt_pkg::S_CLEAR;
      clr_r       <= '0;
      off_r       <= tlbpt_pkg::RST_OFFSET_BITS;
      tlbn_r      <= tlbpt_pkg::RST_TLB_ENTRIES;
      frn_r       <= tlbpt_pkg::RST_FRAMES;
      tlb_vld_r   <= '0;
      tlb_ptr_r   <= '0;
      fr_ptr_r    <= '0;
      fr_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlbpt_pkg::S_CLEAR) begin
        clr_r <= clr_r + PT_AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          tlbpt_pkg::CFG_OFFSET_BITS: off_r  <= cfg_wdata[tlbpt_pkg::OFF_BITS-1:0];
          tlbpt_pkg::CFG_TLB_ENTRIES: tlbn_r <= cfg_wdata[tlbpt_pkg::TLBN_BITS-1:0];
          tlbpt_pkg::CFG_FRAMES:      frn_r  <= cfg_wdata[tlbpt_pkg::FRN_BITS-1:0];
          default: ;
        endcase
      end
      if (tlb_we) begin
        tlb_vld_r[tlb_waddr] <= 1'b1;
        if (!hit_r) begin
          tlb_ptr_r <= tlb_ptr_adv;
        end
      end
      if (alloc) begin
        fr_vld_r[fr_ptr_eff] <= 1'b1;
        fr_ptr_r             <= fr_ptr_adv;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (ld_in) begin
      kind_r <= in_ch.kind;
      data_r <= in_ch.data_word;
      page_r <= PG_W'(page_shift);
      hit_r  <= 1'b0;
    end else if (do_sub) begin
      page_r <= page_r - PG_W'(PAGE_TABLE_DEPTH);
    end
    if (scan_clr) begin
      scan_r <= '0;
    end else if (scan_inc) begin
      scan_r <= scan_r + TLB_CW'(1);
    end
    if (hit_set) begin
      hit_r  <= 1'b1;
      slot_r <= scan_idx;
    end
    if (fr_re) begin
      fcand_r  <= fcand;
      fvld_q_r <= fr_vld_r[fcand];
    end
    if (tlb_we) begin
      tlb_ent_r[tlb_waddr] <= '{page: page_idx, frame: res_frame};
    end
    if (commit) begin
      outcome_r <= res_outcome;
      frame_r   <= res_frame;
      rdata_r   <= res_data;
      dset_r    <= res_dset;
    end
  end

  // Page table memory.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_q_r <= pt_mem[page_idx];
    end
  end

  // Frame store memory.
  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= '{owned: 1'b1, page: page_idx, data: data_r};
    end
    if (fr_re) begin
      fr_q_r <= fr_mem[fcand];
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.outcome   = outcome_r;
  assign out_ch.frame     = frame_r;
  assign out_ch.read_data = rdata_r;
  assign out_ch.dirty_set = dset_r;

  // Once an item is taken the sequencer is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != tlbpt_pkg::S_IDLE))
    else $error("sequencer idle right after taking an item");

  // The page table is only read with a page already folded into its range.
  a_pt_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pt_re |-> (32'(page_r) < 32'(PAGE_TABLE_DEPTH)))
    else $error("page table read with an unreduced page");

  // A newly allocated frame lies within the frames in use.
  a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |-> (FR_CW'(fr_ptr_eff) < fr_lim))
    else $error("frame allocated beyond the frames in use");

  // The TLB fill pointer only moves when an access that missed the TLB commits.
  a_tlb_ptr_moves_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(tlb_ptr_r)) |->
      $past(commit && !hit_r && (kind_r == tlbpt_pkg::KIND_ACCESS)))
    else $error("TLB fill pointer moved without a TLB miss");

  // A result appears only from the decision step.
  a_result_from_decision: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tlbpt_pkg::S_DEC))
    else $error("result produced outside the decision step");

endmodule

// ===== bench/tb_tlb_page_table_translator_unit.sv =====
`timescale 1ns / 1ps

module tb_tlb_page_table_translator_unit;

  localparam int TLB_DEPTH        = 16;
  localparam int PAGE_TABLE_DEPTH = 1024;
  localparam int FRAME_DEPTH      = 128;
  localparam int DATA_BITS        = 32;
  localparam int FRAME_BITS       = 7;

  localparam int VA_BITS       = tlbpt_pkg::VA_BITS;
  localparam int OFF_BITS      = tlbpt_pkg::OFF_BITS;
  localparam int TLBN_BITS     = tlbpt_pkg::TLBN_BITS;
  localparam int FRN_BITS      = tlbpt_pkg::FRN_BITS;
  localparam int CFG_IDX_BITS  = tlbpt_pkg::CFG_IDX_BITS;
  localparam int CFG_DATA_BITS = tlbpt_pkg::CFG_DATA_BITS;

  // A clean reset is followed by a page table sweep with no beat taken, so the
  // watchdog limit sits well above the length of that sweep.
  localparam int WATCHDOG_LIMIT = 4000;
  // The longest access is a full TLB scan; this covers it with margin.
  localparam int SETTLE_CYCLES  = 30;

  // One translation result as it leaves the block.
  typedef struct packed {
    tlbpt_pkg::outcome_t   outcome;
    logic [FRAME_BITS-1:0] frame;
    logic [DATA_BITS-1:0]  read_data;
    logic                  dirty_set;
  } xlat_result_t;

  logic clk;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  tlbpt_in_if  #(.DATA_BITS(DATA_BITS)) in_ch ();
  tlbpt_out_if #(.DATA_BITS(DATA_BITS), .FRAME_BITS(FRAME_BITS)) out_ch ();

  tlb_page_table_translator_unit #(
    .TLB_DEPTH        (TLB_DEPTH),
    .PAGE_TABLE_DEPTH (PAGE_TABLE_DEPTH),
    .FRAME_DEPTH      (FRAME_DEPTH),
    .DATA_BITS        (DATA_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------------
  // Translation predictor. It keeps its own copy of the three registers, the TLB, the
  // page table and the frame store, and is stepped once for every accepted input beat.
  // ---------------------------------------------------------------------------------
  logic [OFF_BITS-1:0]  off_bits;
  logic [TLBN_BITS-1:0] tlb_used;
  logic [FRN_BITS-1:0]  frames_used;

  bit                    tlb_valid [TLB_DEPTH];
  logic [VA_BITS-1:0]    tlb_page  [TLB_DEPTH];
  logic [FRAME_BITS-1:0] tlb_frame [TLB_DEPTH];

  bit                    pt_valid [PAGE_TABLE_DEPTH];
  logic [FRAME_BITS-1:0] pt_frame [PAGE_TABLE_DEPTH];

  bit                    fr_owned [FRAME_DEPTH];
  logic [VA_BITS-1:0]    fr_page  [FRAME_DEPTH];
  logic [DATA_BITS-1:0]  fr_data  [FRAME_DEPTH];

  int tlb_ptr;
  int frame_ptr;

  // Results predicted at input acceptance, oldest first.
  xlat_result_t pending_xlats [$];

  int  error_count;
  bit  idle_on;

  function automatic void clear_translator_state();
    off_bits    = tlbpt_pkg::RST_OFFSET_BITS;
    tlb_used    = tlbpt_pkg::RST_TLB_ENTRIES;
    frames_used = tlbpt_pkg::RST_FRAMES;
    foreach (tlb_valid[i]) begin
      tlb_valid[i] = 1'b0;
      tlb_page[i]  = '0;
      tlb_frame[i] = '0;
    end
    foreach (pt_valid[i]) begin
      pt_valid[i] = 1'b0;
      pt_frame[i] = '0;
    end
    foreach (fr_owned[i]) begin
      fr_owned[i] = 1'b0;
      fr_page[i]  = '0;
      fr_data[i]  = '0;
    end
    tlb_ptr   = 0;
    frame_ptr = 0;
  endfunction

  // Register values outside the usable range are clamped rather than rejected.
  function automatic int tlb_limit();
    if (tlb_used == 0) return 1;
    if (tlb_used > TLB_DEPTH) return TLB_DEPTH;
    return int'(tlb_used);
  endfunction

  function automatic int frame_limit();
    if (frames_used == 0) return 1;
    if (frames_used > FRAME_DEPTH) return FRAME_DEPTH;
    return int'(frames_used);
  endfunction

  // Hands the next FIFO frame to a page. A pointer left beyond the limit by a register
  // change wraps to zero before it is used.
  function automatic logic [FRAME_BITS-1:0] take_frame(logic [VA_BITS-1:0] page,
                                                       logic [DATA_BITS-1:0] data);
    int lim;
    logic [FRAME_BITS-1:0] f;
    lim = frame_limit();
    if (frame_ptr >= lim) frame_ptr = 0;
    f = FRAME_BITS'(frame_ptr);
    fr_owned[f] = 1'b1;
    fr_page[f]  = page;
    fr_data[f]  = data;
    frame_ptr   = (frame_ptr + 1 >= lim) ? 0 : frame_ptr + 1;
    pt_valid[page] = 1'b1;
    pt_frame[page] = f;
    return f;
  endfunction

  function automatic xlat_result_t xlat_lookup(logic kind, logic [VA_BITS-1:0] va,
                                               logic [DATA_BITS-1:0] data);
    xlat_result_t r;
    logic [VA_BITS-1:0] page;
    logic [FRAME_BITS-1:0] f;
    int lim;
    int slot;
    bit hit;
    r    = '0;
    page = va >> off_bits;
    hit  = 1'b0;
    slot = 0;
    if (kind == tlbpt_pkg::KIND_READ) begin
      // A read never touches the TLB. If the frame was taken by another page the
      // current holder's data comes back anyway.
      if (pt_valid[page]) begin
        r.outcome   = tlbpt_pkg::OUT_READ_MAPPED;
        r.frame     = pt_frame[page];
        r.read_data = fr_data[pt_frame[page]];
      end else begin
        r.outcome = tlbpt_pkg::OUT_READ_UNMAPPED;
      end
    end else begin
      lim = tlb_limit();
      for (int i = 0; i < lim; i++) begin
        if (!hit && tlb_valid[i] && tlb_page[i] == page) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (!hit) begin
        if (tlb_ptr >= lim) tlb_ptr = 0;
        slot    = tlb_ptr;
        tlb_ptr = (slot + 1 >= lim) ? 0 : slot + 1;
      end
      if (hit || pt_valid[page]) begin
        if (hit) begin
          f         = tlb_frame[slot];
          r.outcome = tlbpt_pkg::OUT_TLB_HIT;
        end else begin
          f         = pt_frame[page];
          r.outcome = tlbpt_pkg::OUT_PT_HIT;
        end
        if (fr_owned[f] && fr_page[f] == page) begin
          if (fr_data[f] != data) begin
            fr_data[f]  = data;
            r.dirty_set = 1'b1;
          end
        end else begin
          // The frame went to another page; reload. On a TLB hit the same slot is
          // rewritten in place below and the fill pointer stays put.
          f         = take_frame(page, data);
          r.outcome = tlbpt_pkg::OUT_FRAME_LOST;
        end
      end else begin
        f         = take_frame(page, data);
        r.outcome = tlbpt_pkg::OUT_PAGE_LOAD;
      end
      tlb_valid[slot] = 1'b1;
      tlb_page[slot]  = page;
      tlb_frame[slot] = f;
      r.frame         = f;
      r.read_data     = fr_data[f];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------
  // Clock, watchdog and result side.
  // ---------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Counts cycles in which neither channel moves a beat.
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[tlb_page_table_translator_unit] ERROR");
        $finish;
      end
    end
  end

  // Prints one line for each mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                 input logic [DATA_BITS-1:0] want);
    error_count++;
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // The result sink stalls at random while idling is on, and never otherwise.
  always @(negedge clk) begin
    out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 23);
  end

  // Each accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    xlat_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_xlats.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.read_data, '0);
      end else begin
        want = pending_xlats.pop_front();
        if (out_ch.outcome !== want.outcome)
          report_mismatch("outcome", DATA_BITS'(out_ch.outcome), DATA_BITS'(want.outcome));
        if (out_ch.frame !== want.frame)
          report_mismatch("frame", DATA_BITS'(out_ch.frame), DATA_BITS'(want.frame));
        if (out_ch.read_data !== want.read_data)
          report_mismatch("read_data", out_ch.read_data, want.read_data);
        if (out_ch.dirty_set !== want.dirty_set)
          report_mismatch("dirty_set", DATA_BITS'(out_ch.dirty_set),
                          DATA_BITS'(want.dirty_set));
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus. Every task below is entered and left just after a falling edge, so input
  // changes always land at the falling edge and valid is never lowered and raised in
  // the same step.
  // ---------------------------------------------------------------------------------

  // Sends one input beat, with a random gap ahead of it while idling is on. The
  // prediction is made at the rising edge on which the beat is accepted. Valid is left
  // high so that back-to-back beats follow without a gap.
  task automatic send_beat(input logic kind, input logic [VA_BITS-1:0] va,
                           input logic [DATA_BITS-1:0] data);
    while (idle_on && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.kind            <= kind;
    in_ch.virtual_address <= va;
    in_ch.data_word       <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_xlats.push_back(xlat_lookup(kind, va, data));
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has come back, then lets the
  // block settle, so that registers are only ever written while it is idle.
  task automatic drain_pending();
    in_ch.valid <= 1'b0;
    while (pending_xlats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write. The enable is dropped after the write is sampled, in its own step.
  task automatic set_reg(input tlbpt_pkg::cfg_idx_t idx,
                         input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      tlbpt_pkg::CFG_OFFSET_BITS: off_bits    = value[OFF_BITS-1:0];
      tlbpt_pkg::CFG_TLB_ENTRIES: tlb_used    = value[TLBN_BITS-1:0];
      tlbpt_pkg::CFG_FRAMES:      frames_used = value[FRN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all_regs(input logic [CFG_DATA_BITS-1:0] off,
                              input logic [CFG_DATA_BITS-1:0] tlbn,
                              input logic [CFG_DATA_BITS-1:0] frn);
    drain_pending();
    set_reg(tlbpt_pkg::CFG_OFFSET_BITS, off);
    set_reg(tlbpt_pkg::CFG_TLB_ENTRIES, tlbn);
    set_reg(tlbpt_pkg::CFG_FRAMES, frn);
  endtask

  // Reset settings: the plain paths through the block, with the data word at both
  // extremes and the address at both ends of its range.
  task automatic test_basic_paths();
    send_beat(tlbpt_pkg::KIND_READ,   10'd0,    32'h0000_0000);  // unmapped page
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd0,    32'h0000_0000);  // first touch loads
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd0,    32'h0000_0000);  // TLB hit, stays clean
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd3,    32'hFFFF_FFFF);  // new data sets dirty
    send_beat(tlbpt_pkg::KIND_READ,   10'd1,    32'hDEAD_BEEF);  // mapped page
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd1023, 32'hA5A5_A5A5);
    send_beat(tlbpt_pkg::KIND_READ,   10'd1023, 32'h0000_0000);
  endtask

  // Frames taken away from their pages, seen through the page table, through the
  // TLB and through a read, with the registers at and below their lowest values.
  task automatic test_lost_frames();
    // One TLB slot and one frame: every new page steals from the last one.
    set_all_regs(8'd0, 8'd0, 8'd0);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd5, 32'h1111_1111);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd6, 32'h2222_2222);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd5, 32'h1111_1111);  // page table hit, lost
    send_beat(tlbpt_pkg::KIND_READ,   10'd6, 32'h0);          // sees the thief's data
    send_beat(tlbpt_pkg::KIND_READ,   10'd7, 32'h0);
    // Plenty of frames but still one TLB slot: a plain page table hit.
    drain_pending();
    set_reg(tlbpt_pkg::CFG_FRAMES, 8'd128);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd20, 32'h3333_3333);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd21, 32'h4444_4444);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd20, 32'h3333_3333);
    // A full TLB and two frames: page 10 stays in the TLB while its frame is reused,
    // so the next access hits a stale TLB slot and reloads it in place.
    set_all_regs(8'd0, 8'd16, 8'd2);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd10, 32'h5555_5555);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd11, 32'h6666_6666);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd12, 32'h7777_7777);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd10, 32'h8888_8888);
  endtask

  // Register values beyond their ranges, and the widest page offsets.
  task automatic test_register_limits();
    set_all_regs(8'd15, 8'd31, 8'd255);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd0,    32'h1234_5678);  // all addresses page 0
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd1023, 32'h1234_5678);
    drain_pending();
    set_reg(tlbpt_pkg::CFG_OFFSET_BITS, 8'd9);
    send_beat(tlbpt_pkg::KIND_ACCESS, 10'd512,  32'h0000_0000);
    send_beat(tlbpt_pkg::KIND_READ,   10'd1023, 32'h0000_0000);
    send_beat(tlbpt_pkg::KIND_READ,   10'd0,    32'h0000_0000);
  endtask

  // One phase of random traffic. Most addresses come from a small set of hot pages
  // (with a random offset) so that hits, reloads and dirty writes all happen; the
  // rest are spread over the whole space. Half of the data words repeat from a small
  // pool so that rewrites of equal data are common.
  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] off,
                           input logic [CFG_DATA_BITS-1:0] tlbn,
                           input logic [CFG_DATA_BITS-1:0] frn,
                           input int beats, input bit idling);
    logic [VA_BITS-1:0]   hot_pages [24];
    logic [DATA_BITS-1:0] word_pool [4];
    int n_hot;
    logic kind;
    logic [VA_BITS-1:0] va;
    logic [DATA_BITS-1:0] data;
    set_all_regs(off, tlbn, frn);
    idle_on = idling;
    n_hot = $urandom_range(1, 24);
    foreach (hot_pages[i]) hot_pages[i] = VA_BITS'($urandom_range(0, 1023));
    foreach (word_pool[i]) word_pool[i] = $urandom;
    repeat (beats) begin
      kind = ($urandom_range(0, 99) < 25) ? tlbpt_pkg::KIND_READ : tlbpt_pkg::KIND_ACCESS;
      if ($urandom_range(0, 9) == 0)
        va = VA_BITS'($urandom_range(0, 1023));
      else
        va = hot_pages[$urandom_range(0, n_hot - 1)] ^ VA_BITS'($urandom_range(0, 3));
      data = ($urandom_range(0, 1) == 0) ? word_pool[$urandom_range(0, 3)] : $urandom;
      send_beat(kind, va, data);
    end
  endtask

  task automatic test_random_traffic();
    run_phase(8'd0,  8'd1,  8'd1,   120, 1'b1);
    run_phase(8'd9,  8'd16, 8'd128, 180, 1'b1);
    run_phase(8'd15, 8'd31, 8'd255, 60,  1'b1);
    run_phase(8'd2,  8'd10, 8'd32,  200, 1'b1);
    repeat (4) begin
      run_phase(CFG_DATA_BITS'($urandom_range(0, 15)), CFG_DATA_BITS'($urandom_range(0, 31)),
                CFG_DATA_BITS'($urandom_range(0, 255)), 180, 1'b1);
    end
  endtask

  // A long stretch with both sides always willing, so beats run back to back.
  task automatic test_no_idle_stretch();
    run_phase(CFG_DATA_BITS'($urandom_range(0, 9)), CFG_DATA_BITS'($urandom_range(1, 16)),
              CFG_DATA_BITS'($urandom_range(1, 64)), 200, 1'b0);
    idle_on = 1'b1;
  endtask

  initial begin
    // Every input is known from time zero.
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = tlbpt_pkg::KIND_ACCESS;
    in_ch.virtual_address = '0;
    in_ch.data_word       = '0;
    out_ch.ready          = 1'b0;
    error_count           = 0;
    quiet_cycles          = 0;
    idle_on               = 1'b1;
    clear_translator_state();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_paths();
    test_lost_frames();
    test_register_limits();
    test_random_traffic();
    test_no_idle_stretch();

    drain_pending();
    if (error_count == 0) begin
      $display("[tlb_page_table_translator_unit] OK");
    end else begin
      $display("[tlb_page_table_translator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_if.sv
hw/rtl/tlb_page_table_translator_unit.sv
bench/tb_tlb_page_table_translator_unit.sv
